FILE: hdl/blocked_array_address_unit_macros.svh
// Assertion macros shared by the checker of blocked_array_address_unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BLOCKED_ARRAY_ADDRESS_UNIT_MACROS_SVH
`define BLOCKED_ARRAY_ADDRESS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BAAU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define BAAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: hdl/baau_pkg.sv
// Package for the blocked array address unit: field widths, register
// indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package baau_pkg;

    localparam int COORD_W      = 12;
    localparam int OFFSET_W     = 16;
    localparam int CFG_DIM_W    = 13;
    localparam int CFG_SIDE_W   = 9;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DIM_MAX  = (1 << CFG_DIM_W) - 1;
    localparam int CFG_SIDE_MAX = (1 << CFG_SIDE_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_ARRAY_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ARRAY_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_SIDE    = 2'd2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WALK   = 1'b1;

    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COORD_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_C,
        ST_DIV_R,
        ST_LK_MUL,
        ST_LK_ADD,
        ST_WK_BASE_C,
        ST_WK_BASE_R,
        ST_WK_CHECK,
        ST_WK_ADJUST,
        ST_WK_OFF,
        ST_WK_STEP,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/blocked_array_address_unit.sv
// Blocked array address unit: maps coordinates to tile and in-tile offset,
// and steps a block-major walk. Depends on baau_pkg.
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  ------------------------------------------
// in       sink       in_valid / in_stall    opcode, column, row
// out      source     out_valid / out_stall  elem_column, elem_row, tile_column,
//                                            tile_row, tile_offset, out_of_range, last
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// In-range lookup: two passes of the restoring divider, one multiply, one add, one load.
// Walk step: three of its states use the shared multiplier.
// Out-of-range lookup or walk on an empty array: goes straight to the load.
// in_stall is high while an item is in work; the output register lets the next
// request in while a result waits. Reset sets width and height to zero, side to one,
// and clears the walk position and out_valid.
`timescale 1ns / 1ps

module blocked_array_address_unit
    import baau_pkg::*;
#(
    parameter int MAX_DIM       = 4096,
    parameter int MAX_TILE_SIDE = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [COORD_W-1:0]     column,
    input  logic [COORD_W-1:0]     row,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_W-1:0]     elem_column,
    output logic [COORD_W-1:0]     elem_row,
    output logic [COORD_W-1:0]     tile_column,
    output logic [COORD_W-1:0]     tile_row,
    output logic [OFFSET_W-1:0]    tile_offset,
    output logic                   out_of_range,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DIM_MAX  = (MAX_DIM > CFG_DIM_MAX) ? CFG_DIM_MAX : MAX_DIM;
    localparam int SIDE_MAX = (MAX_TILE_SIDE > CFG_SIDE_MAX) ? CFG_SIDE_MAX : MAX_TILE_SIDE;
    localparam int DW = $clog2(DIM_MAX + 1);
    localparam int SW = $clog2(SIDE_MAX + 1);
    localparam int IW = $clog2(SIDE_MAX);
    localparam int MW = (DW > IW) ? DW : IW;
    localparam int PW = MW + SW;
    localparam int EW = PW + 1;

    state_t state_reg, state_next;

    logic [CFG_DIM_W-1:0]  cfg_width_reg, cfg_width_next;
    logic [CFG_DIM_W-1:0]  cfg_height_reg, cfg_height_next;
    logic [CFG_SIDE_W-1:0] cfg_side_reg, cfg_side_next;

    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DW-1:0]         wtc_reg, wtc_next;
    logic [DW-1:0]         wtr_reg, wtr_next;
    logic [IW-1:0]         wir_reg, wir_next;
    logic [IW-1:0]         wic_reg, wic_next;
    logic                  out_valid_reg, out_valid_next;

    logic [COORD_W-1:0]    quo_reg, quo_next;
    logic [SW-1:0]         rem_reg, rem_next;
    logic [COORD_W-1:0]    col_reg, col_next;
    logic [COORD_W-1:0]    row_reg, row_next;
    logic [COORD_W-1:0]    tcol_reg, tcol_next;
    logic [IW-1:0]         rcol_reg, rcol_next;
    logic [IW-1:0]         rrow_reg, rrow_next;
    logic [PW-1:0]         mul_reg, mul_next;
    logic [PW-1:0]         base_c_reg, base_c_next;
    logic [PW-1:0]         base_r_reg, base_r_next;

    logic [COORD_W-1:0]    res_col_reg, res_col_next;
    logic [COORD_W-1:0]    res_row_reg, res_row_next;
    logic [COORD_W-1:0]    res_tcol_reg, res_tcol_next;
    logic [COORD_W-1:0]    res_trow_reg, res_trow_next;
    logic [OFFSET_W-1:0]   res_off_reg, res_off_next;
    logic                  res_oor_reg, res_oor_next;
    logic                  res_last_reg, res_last_next;

    logic [COORD_W-1:0]    out_col_reg, out_col_next;
    logic [COORD_W-1:0]    out_row_reg, out_row_next;
    logic [COORD_W-1:0]    out_tcol_reg, out_tcol_next;
    logic [COORD_W-1:0]    out_trow_reg, out_trow_next;
    logic [OFFSET_W-1:0]   out_off_reg, out_off_next;
    logic                  out_oor_reg, out_oor_next;
    logic                  out_last_reg, out_last_next;

    logic [DW-1:0]  w_eff, h_eff;
    logic [SW-1:0]  s_eff;
    logic [MW-1:0]  mul_a;
    logic [SW:0]    rem_sh;
    logic           div_ge;
    logic [SW-1:0]  rem_new;
    logic [COORD_W-1:0] quo_new;
    logic [EW-1:0]  diff_c, diff_r;
    logic [SW-1:0]  cw, rh;
    logic           edge_c, edge_r;
    logic [SW-1:0]  ir_inc, ic_inc;
    logic [DW-1:0]  nt_tc, nt_tr;
    logic [PW-1:0]  nt_bc, nt_br;
    logic           lookup_oor, stale, accept;

    // Effective register values after clamping.
    always_comb
    begin
        if (int'(cfg_width_reg) > DIM_MAX)
            w_eff = DW'(DIM_MAX);
        else
            w_eff = cfg_width_reg[DW-1:0];
        if (int'(cfg_height_reg) > DIM_MAX)
            h_eff = DW'(DIM_MAX);
        else
            h_eff = cfg_height_reg[DW-1:0];
        if (cfg_side_reg == '0)
            s_eff = SW'(1);
        else if (int'(cfg_side_reg) > SIDE_MAX)
            s_eff = SW'(SIDE_MAX);
        else
            s_eff = cfg_side_reg[SW-1:0];
    end

    // Shared multiplier: operand picked by the sequencer, product lands next cycle.
    always_comb
    begin
        case (state_reg)
            ST_WK_BASE_C: mul_a = MW'(wtc_reg);
            ST_WK_BASE_R: mul_a = MW'(wtr_reg);
            ST_LK_MUL:    mul_a = MW'(rcol_reg);
            ST_WK_OFF:    mul_a = MW'(wic_reg);
            default:      mul_a = '0;
        endcase
        mul_next = PW'(mul_a) * PW'(s_eff);
    end

    // One restoring divide step per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[COORD_W-1]};
        div_ge  = rem_sh >= {1'b0, s_eff};
        rem_new = div_ge ? SW'(rem_sh - {1'b0, s_eff}) : rem_sh[SW-1:0];
        quo_new = {quo_reg[COORD_W-2:0], div_ge};
    end

    // Extent of the current tile and position of the following tile in walk order.
    always_comb
    begin
        diff_c = EW'(w_eff) - EW'(base_c_reg);
        diff_r = EW'(h_eff) - EW'(base_r_reg);
        cw = (diff_c >= EW'(s_eff)) ? s_eff : diff_c[SW-1:0];
        rh = (diff_r >= EW'(s_eff)) ? s_eff : diff_r[SW-1:0];
        edge_c = (EW'(base_c_reg) + EW'(s_eff)) >= EW'(w_eff);
        edge_r = (EW'(base_r_reg) + EW'(s_eff)) >= EW'(h_eff);
        ir_inc = SW'(wir_reg) + SW'(1);
        ic_inc = SW'(wic_reg) + SW'(1);
        nt_tc = wtc_reg;
        nt_tr = wtr_reg;
        nt_bc = base_c_reg;
        nt_br = base_r_reg;
        if (edge_c)
        begin
            nt_tc = '0;
            nt_bc = '0;
            if (edge_r)
            begin
                nt_tr = '0;
                nt_br = '0;
            end
            else
            begin
                nt_tr = wtr_reg + DW'(1);
                nt_br = PW'(EW'(base_r_reg) + EW'(s_eff));
            end
        end
        else
        begin
            nt_tc = wtc_reg + DW'(1);
            nt_bc = PW'(EW'(base_c_reg) + EW'(s_eff));
        end
    end

    assign lookup_oor = ({1'b0, column} >= CFG_DIM_W'(w_eff))
                     || ({1'b0, row} >= CFG_DIM_W'(h_eff));
    assign stale = (EW'(base_c_reg) >= EW'(w_eff)) || (EW'(mul_reg) >= EW'(h_eff))
                || (SW'(wir_reg) >= s_eff) || (SW'(wic_reg) >= s_eff);
    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        cfg_side_next   = cfg_side_reg;
        cnt_next        = cnt_reg;
        wtc_next        = wtc_reg;
        wtr_next        = wtr_reg;
        wir_next        = wir_reg;
        wic_next        = wic_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        tcol_next       = tcol_reg;
        rcol_next       = rcol_reg;
        rrow_next       = rrow_reg;
        base_c_next     = base_c_reg;
        base_r_next     = base_r_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        res_tcol_next   = res_tcol_reg;
        res_trow_next   = res_trow_reg;
        res_off_next    = res_off_reg;
        res_oor_next    = res_oor_reg;
        res_last_next   = res_last_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_tcol_next   = out_tcol_reg;
        out_trow_next   = out_trow_reg;
        out_off_next    = out_off_reg;
        out_oor_next    = out_oor_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ARRAY_WIDTH:  cfg_width_next  = cfg_data[CFG_DIM_W-1:0];
                REG_ARRAY_HEIGHT: cfg_height_next = cfg_data[CFG_DIM_W-1:0];
                REG_TILE_SIDE:    cfg_side_next   = cfg_data[CFG_SIDE_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next = column;
                    row_next = row;
                    if (opcode == OP_LOOKUP)
                    begin
                        if (lookup_oor)
                        begin
                            res_col_next  = column;
                            res_row_next  = row;
                            res_tcol_next = '0;
                            res_trow_next = '0;
                            res_off_next  = '0;
                            res_oor_next  = 1'b1;
                            res_last_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            quo_next   = column;
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DIV_C;
                        end
                    end
                    else if (w_eff == '0 || h_eff == '0)
                    begin
                        wtc_next      = '0;
                        wtr_next      = '0;
                        wir_next      = '0;
                        wic_next      = '0;
                        res_col_next  = '0;
                        res_row_next  = '0;
                        res_tcol_next = '0;
                        res_trow_next = '0;
                        res_off_next  = '0;
                        res_oor_next  = 1'b1;
                        res_last_next = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WK_BASE_C;
                    end
                end
            end

            ST_DIV_C:
            begin
                quo_next = quo_new;
                rem_next = rem_new;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    tcol_next  = quo_new;
                    rcol_next  = IW'(rem_new);
                    quo_next   = row_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV_R;
                end
            end

            ST_DIV_R:
            begin
                quo_next = quo_new;
                rem_next = rem_new;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    res_trow_next = quo_new;
                    rrow_next     = IW'(rem_new);
                    cnt_next      = '0;
                    state_next    = ST_LK_MUL;
                end
            end

            ST_LK_MUL:
            begin
                state_next = ST_LK_ADD;
            end

            ST_LK_ADD:
            begin
                res_col_next  = col_reg;
                res_row_next  = row_reg;
                res_tcol_next = tcol_reg;
                res_off_next  = OFFSET_W'(EW'(mul_reg) + EW'(rrow_reg));
                res_oor_next  = 1'b0;
                res_last_next = 1'b0;
                state_next    = ST_DONE;
            end

            ST_WK_BASE_C:
            begin
                state_next = ST_WK_BASE_R;
            end

            ST_WK_BASE_R:
            begin
                base_c_next = mul_reg;
                state_next  = ST_WK_CHECK;
            end

            ST_WK_CHECK:
            begin
                // Restart from the first cell when the stored position left the grid.
                if (stale)
                begin
                    wtc_next    = '0;
                    wtr_next    = '0;
                    wir_next    = '0;
                    wic_next    = '0;
                    base_c_next = '0;
                    base_r_next = '0;
                end
                else
                begin
                    base_r_next = mul_reg;
                end
                state_next = ST_WK_ADJUST;
            end

            ST_WK_ADJUST:
            begin
                // Skip past cells cut off by the right or bottom edge.
                if (SW'(wir_reg) >= rh)
                begin
                    wtc_next    = nt_tc;
                    wtr_next    = nt_tr;
                    base_c_next = nt_bc;
                    base_r_next = nt_br;
                    wir_next    = '0;
                    wic_next    = '0;
                end
                else if (SW'(wic_reg) >= cw)
                begin
                    wic_next = '0;
                    if (ir_inc >= rh)
                    begin
                        wtc_next    = nt_tc;
                        wtr_next    = nt_tr;
                        base_c_next = nt_bc;
                        base_r_next = nt_br;
                        wir_next    = '0;
                    end
                    else
                    begin
                        wir_next = IW'(ir_inc);
                    end
                end
                state_next = ST_WK_OFF;
            end

            ST_WK_OFF:
            begin
                state_next = ST_WK_STEP;
            end

            ST_WK_STEP:
            begin
                res_col_next  = COORD_W'(EW'(base_c_reg) + EW'(wic_reg));
                res_row_next  = COORD_W'(EW'(base_r_reg) + EW'(wir_reg));
                res_tcol_next = COORD_W'(wtc_reg);
                res_trow_next = COORD_W'(wtr_reg);
                res_off_next  = OFFSET_W'(EW'(mul_reg) + EW'(wir_reg));
                res_oor_next  = 1'b0;
                res_last_next = edge_c && edge_r && (ir_inc == rh) && (ic_inc == cw);
                // Advance to the next cell.
                if (ic_inc >= cw)
                begin
                    wic_next = '0;
                    if (ir_inc >= rh)
                    begin
                        wtc_next    = nt_tc;
                        wtr_next    = nt_tr;
                        base_c_next = nt_bc;
                        base_r_next = nt_br;
                        wir_next    = '0;
                    end
                    else
                    begin
                        wir_next = IW'(ir_inc);
                    end
                end
                else
                begin
                    wic_next = IW'(ic_inc);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_col_next   = res_col_reg;
                    out_row_next   = res_row_reg;
                    out_tcol_next  = res_tcol_reg;
                    out_trow_next  = res_trow_reg;
                    out_off_next   = res_off_reg;
                    out_oor_next   = res_oor_reg;
                    out_last_next  = res_last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= '0;
            cfg_height_reg <= '0;
            cfg_side_reg   <= CFG_SIDE_W'(1);
            cnt_reg        <= '0;
            wtc_reg        <= '0;
            wtr_reg        <= '0;
            wir_reg        <= '0;
            wic_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            cfg_side_reg   <= cfg_side_next;
            cnt_reg        <= cnt_next;
            wtc_reg        <= wtc_next;
            wtr_reg        <= wtr_next;
            wir_reg        <= wir_next;
            wic_reg        <= wic_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        tcol_reg     <= tcol_next;
        rcol_reg     <= rcol_next;
        rrow_reg     <= rrow_next;
        mul_reg      <= mul_next;
        base_c_reg   <= base_c_next;
        base_r_reg   <= base_r_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_tcol_reg <= res_tcol_next;
        res_trow_reg <= res_trow_next;
        res_off_reg  <= res_off_next;
        res_oor_reg  <= res_oor_next;
        res_last_reg <= res_last_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_tcol_reg <= out_tcol_next;
        out_trow_reg <= out_trow_next;
        out_off_reg  <= out_off_next;
        out_oor_reg  <= out_oor_next;
        out_last_reg <= out_last_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign elem_column  = out_col_reg;
    assign elem_row     = out_row_reg;
    assign tile_column  = out_tcol_reg;
    assign tile_row     = out_trow_reg;
    assign tile_offset  = out_off_reg;
    assign out_of_range = out_oor_reg;
    assign last         = out_last_reg;

endmodule

FILE: hdl/baau_checker.sv
// Port-level checker for blocked_array_address_unit, attached by bind.
// Depends on baau_pkg and blocked_array_address_unit_macros.svh.
`timescale 1ns / 1ps
`include "blocked_array_address_unit_macros.svh"

module baau_checker
    import baau_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [COORD_W-1:0]     elem_column,
    input logic [COORD_W-1:0]     elem_row,
    input logic [COORD_W-1:0]     tile_column,
    input logic [COORD_W-1:0]     tile_row,
    input logic [OFFSET_W-1:0]    tile_offset,
    input logic                   out_of_range,
    input logic                   last
);

    // Hold a stalled result.
    `BAAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `BAAU_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(elem_column) && $stable(tile_offset) && $stable(last))

    // One request at a time: an accepted request closes the input.
    `BAAU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // Out-of-range results carry no tile position.
    `BAAU_ASSERT_NOW(a_oor_zero_tile, out_valid && out_of_range,
        tile_column == '0 && tile_row == '0 && tile_offset == '0)

    // Walk on an empty array reports the origin.
    `BAAU_ASSERT_NOW(a_empty_walk_origin, out_valid && out_of_range && last,
        elem_column == '0 && elem_row == '0)

endmodule

bind blocked_array_address_unit baau_checker u_baau_checker (.*);

FILE: tb/tb_blocked_array_address_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for blocked_array_address_unit: sends lookup and walk
// requests, predicts each tile address in a behavioral model and checks the output.
// Depends on baau_pkg and the blocked_array_address_unit RTL.

module tb_blocked_array_address_unit;
    import baau_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int MAX_TILE_SIDE = 256;
    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0]  elem_column;
        logic [COORD_W-1:0]  elem_row;
        logic [COORD_W-1:0]  tile_column;
        logic [COORD_W-1:0]  tile_row;
        logic [OFFSET_W-1:0] tile_offset;
        logic                out_of_range;
        logic                last;
    } tile_addr_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   opcode;
    logic [COORD_W-1:0]     column;
    logic [COORD_W-1:0]     row;
    logic                   out_valid;
    logic                   out_stall;
    logic [COORD_W-1:0]     elem_column;
    logic [COORD_W-1:0]     elem_row;
    logic [COORD_W-1:0]     tile_column;
    logic [COORD_W-1:0]     tile_row;
    logic [OFFSET_W-1:0]    tile_offset;
    logic                   out_of_range;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // model copy of the registers and of the walk position
    logic [CFG_DIM_W-1:0]  reg_width  = '0;
    logic [CFG_DIM_W-1:0]  reg_height = '0;
    logic [CFG_SIDE_W-1:0] reg_side   = 9'd1;
    int unsigned pos_tile_col = 0;
    int unsigned pos_tile_row = 0;
    int unsigned pos_cell_row = 0;
    int unsigned pos_cell_col = 0;

    tile_addr_t expected_addr_q[$];
    int         mismatch_count = 0;
    bit         gaps_on = 1'b0;

    blocked_array_address_unit #(
        .MAX_DIM       (MAX_DIM),
        .MAX_TILE_SIDE (MAX_TILE_SIDE)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .elem_column  (elem_column),
        .elem_row     (elem_row),
        .tile_column  (tile_column),
        .tile_row     (tile_row),
        .tile_offset  (tile_offset),
        .out_of_range (out_of_range),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned edge_span(int unsigned s, int unsigned dim,
                                              int unsigned tile);
        int unsigned rest;
        rest = dim - tile * s;
        return (rest < s) ? rest : s;
    endfunction

    function automatic void advance_tile(int unsigned nx, int unsigned ny);
        pos_cell_row = 0;
        pos_cell_col = 0;
        pos_tile_col++;
        if (pos_tile_col >= nx)
        begin
            pos_tile_col = 0;
            pos_tile_row++;
            if (pos_tile_row >= ny)
                pos_tile_row = 0;
        end
    endfunction

    function automatic tile_addr_t map_cell(logic op, logic [COORD_W-1:0] c_in,
                                            logic [COORD_W-1:0] r_in);
        tile_addr_t  a;
        int unsigned s, w, h, nx, ny, cw, rh, tc, tr, ic, ir;
        a = '0;
        s = (reg_side == 0) ? 1 : reg_side;
        if (s > MAX_TILE_SIDE)
            s = MAX_TILE_SIDE;
        w = (reg_width > MAX_DIM) ? MAX_DIM : reg_width;
        h = (reg_height > MAX_DIM) ? MAX_DIM : reg_height;

        if (op == OP_LOOKUP)
        begin
            a.elem_column = c_in;
            a.elem_row    = r_in;
            if (c_in >= w || r_in >= h)
                a.out_of_range = 1'b1;
            else
            begin
                a.tile_column = COORD_W'(c_in / s);
                a.tile_row    = COORD_W'(r_in / s);
                a.tile_offset = OFFSET_W'((c_in % s) * s + r_in % s);
            end
            return a;
        end

        if (w == 0 || h == 0)
        begin
            pos_tile_col = 0;
            pos_tile_row = 0;
            pos_cell_row = 0;
            pos_cell_col = 0;
            a.out_of_range = 1'b1;
            a.last         = 1'b1;
            return a;
        end

        nx = (w + s - 1) / s;
        ny = (h + s - 1) / s;
        // restart when the stored position falls outside the tile grid
        if (pos_tile_col >= nx || pos_tile_row >= ny || pos_cell_row >= s ||
            pos_cell_col >= s)
        begin
            pos_tile_col = 0;
            pos_tile_row = 0;
            pos_cell_row = 0;
            pos_cell_col = 0;
        end

        // skip past an edge the position may have been left beyond
        cw = edge_span(s, w, pos_tile_col);
        rh = edge_span(s, h, pos_tile_row);
        if (pos_cell_row >= rh)
            advance_tile(nx, ny);
        else if (pos_cell_col >= cw)
        begin
            pos_cell_col = 0;
            pos_cell_row++;
            if (pos_cell_row >= rh)
                advance_tile(nx, ny);
        end

        tc = pos_tile_col;
        tr = pos_tile_row;
        ir = pos_cell_row;
        ic = pos_cell_col;
        cw = edge_span(s, w, tc);
        rh = edge_span(s, h, tr);
        a.elem_column = COORD_W'(tc * s + ic);
        a.elem_row    = COORD_W'(tr * s + ir);
        a.tile_column = COORD_W'(tc);
        a.tile_row    = COORD_W'(tr);
        a.tile_offset = OFFSET_W'(ic * s + ir);
        a.last = (tc == nx - 1) && (tr == ny - 1) && (ir == rh - 1) && (ic == cw - 1);

        pos_cell_col = ic + 1;
        if (pos_cell_col >= cw)
        begin
            pos_cell_col = 0;
            pos_cell_row = ir + 1;
            if (pos_cell_row >= rh)
                advance_tile(nx, ny);
        end
        return a;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic string format_addr(tile_addr_t a);
        return $sformatf("cell (%0d,%0d) tile (%0d,%0d) offset %0d oor %0b last %0b",
                         a.elem_column, a.elem_row, a.tile_column, a.tile_row,
                         a.tile_offset, a.out_of_range, a.last);
    endfunction

    always @(posedge clk)
    begin
        tile_addr_t got;
        tile_addr_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {elem_column, elem_row, tile_column, tile_row, tile_offset,
                   out_of_range, last};
            if (expected_addr_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no request pending: %s", $realtime,
                             format_addr(got));
            end
            else
            begin
                want = expected_addr_q.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                 format_addr(want), format_addr(got));
                end
            end
        end
    end

    // random backpressure on the result side
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_request(logic op, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        column   <= c;
        row      <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_addr_q.push_back(map_cell(op, c, r));
    endtask

    task automatic send_walk_step();
        send_request(OP_WALK, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic send_lookup();
        int unsigned        lim_w;
        int unsigned        lim_h;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        lim_w = (reg_width > MAX_DIM) ? MAX_DIM : reg_width;
        lim_h = (reg_height > MAX_DIM) ? MAX_DIM : reg_height;
        c = COORD_W'($urandom);
        r = COORD_W'($urandom);
        // aim most lookups inside the array
        if (lim_w != 0 && lim_h != 0 && $urandom_range(0, 3) != 0)
        begin
            c = COORD_W'($urandom_range(0, lim_w - 1));
            r = COORD_W'($urandom_range(0, lim_h - 1));
        end
        send_request(OP_LOOKUP, c, r);
    endtask

    // drop valid and hold until every pending request has produced its result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_addr_q.size() != 0 || in_stall)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ARRAY_WIDTH:  reg_width  = data;
            REG_ARRAY_HEIGHT: reg_height = data;
            REG_TILE_SIDE:    reg_side   = data[CFG_SIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                             logic [CFG_DATA_W-1:0] s);
        drain_results();
        write_register(REG_ARRAY_WIDTH, w);
        write_register(REG_ARRAY_HEIGHT, h);
        write_register(REG_TILE_SIDE, s);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dimension(bit compact);
        case ($urandom_range(0, compact ? 19 : 9))
            0: return '0;
            1: return CFG_DATA_W'(MAX_DIM);
            2: return CFG_DATA_W'($urandom_range(MAX_DIM + 1, CFG_DIM_MAX));
            3: return CFG_DATA_W'(1);
            default: return compact ? CFG_DATA_W'($urandom_range(1, 10))
                                    : CFG_DATA_W'($urandom_range(1, MAX_DIM));
        endcase
    endfunction

    function automatic logic [CFG_SIDE_W-1:0] pick_side(bit compact);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_SIDE_W'(MAX_TILE_SIDE);
            2: return CFG_SIDE_W'($urandom_range(MAX_TILE_SIDE + 1, CFG_SIDE_MAX));
            3: return CFG_SIDE_W'(1);
            default: return compact ? CFG_SIDE_W'($urandom_range(2, 6))
                                    : CFG_SIDE_W'($urandom_range(2, MAX_TILE_SIDE));
        endcase
    endfunction

    // bits above the side field are don't-care, so fill them at random
    task automatic configure_random(bit compact);
        configure(pick_dimension(compact), pick_dimension(compact),
                  {4'($urandom), pick_side(compact)});
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_lookups();
        gaps_on = 1'b1;
        // reset values: empty array, side one
        send_request(OP_LOOKUP, '0, '0);
        send_walk_step();
        drain_results();
        write_register(REG_NONE, '1);
        configure(13'd4096, 13'd4096, 13'd256);
        send_request(OP_LOOKUP, '0, '0);
        send_request(OP_LOOKUP, '1, '1);
        send_request(OP_LOOKUP, '1, '0);
        send_request(OP_LOOKUP, '0, '1);
        send_request(OP_LOOKUP, 12'd300, 12'd257);
        // oversized dimensions and side clamp to their limits
        configure(13'h1FFF, 13'd4097, 13'h1FFF);
        send_request(OP_LOOKUP, '1, '1);
        send_walk_step();
        // side field of zero acts as one
        configure(13'd100, 13'd50, 13'h0600);
        send_request(OP_LOOKUP, 12'd99, 12'd49);
        send_request(OP_LOOKUP, 12'd100, 12'd0);
        send_request(OP_LOOKUP, 12'd0, 12'd50);
    endtask

    task automatic test_walk_wrap();
        // two tiles, the right one clipped; run past the last cell
        configure(13'd3, 13'd2, 13'd2);
        repeat (7)
            send_walk_step();
    endtask

    task automatic test_stale_walk();
        configure(13'd6, 13'd6, 13'd3);
        repeat (5)
            send_walk_step();
        // narrow the array so the stored cell lies past the right edge
        configure(13'd2, 13'd6, 13'd3);
        send_walk_step();
        // shrink the side below the stored inner row: walk restarts
        configure(13'd6, 13'd6, 13'd1);
        send_walk_step();
    endtask

    task automatic test_random_lookups();
        for (int phase = 0; phase < 8; phase++)
        begin
            gaps_on = (phase % 3 != 2);
            configure_random(1'b0);
            repeat (60)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_walk_step();
                else
                    send_lookup();
            end
        end
    endtask

    task automatic test_random_walks();
        for (int phase = 0; phase < 10; phase++)
        begin
            gaps_on = (phase % 4 != 1);
            configure_random(phase % 4 != 3);
            for (int n = 0; n < 70; n++)
            begin
                // hold off the sender until the unit has emptied
                if (n == 35)
                    drain_results();
                if ($urandom_range(0, 19) < 17)
                    send_walk_step();
                else
                    send_lookup();
            end
        end
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        for (int phase = 0; phase < 3; phase++)
        begin
            configure_random(phase != 1);
            repeat (70)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_walk_step();
                else
                    send_lookup();
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_LOOKUP;
        column    <= '0;
        row       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ARRAY_WIDTH;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lookups();
        test_walk_wrap();
        test_stale_walk();
        test_random_lookups();
        test_random_walks();
        test_steady_stream();

        drain_results();
        // leave room for any stray result
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
